// ===== rtl/nds_pkg.sv =====
`timescale 1ns / 1ps

package nds_pkg;

	localparam logic [3:0] ESC_NIBBLE = 4'h8;
	localparam int SAMPLE_W = 12;

	// bytes that one accepted item produces, in output order
	typedef struct packed {
		logic       two;
		logic [7:0] b0;
		logic [7:0] b1;
	} job_t;

endpackage

// ===== rtl/nds_front.sv =====
`timescale 1ns / 1ps

module nds_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           take,
	input  logic                           mode,
	input  logic [nds_pkg::SAMPLE_W-1:0]   sample,
	output logic                           job_push,
	output nds_pkg::job_t                  job
);

	logic [nds_pkg::SAMPLE_W-1:0] prev_q, prev_d;
	logic                         started_q, started_d;
	logic                         half_q, half_d;
	logic [3:0]                   held_q, held_d;

	logic [nds_pkg::SAMPLE_W:0]   diff;
	logic                         step_ok;
	logic                         any;
	logic [3:0]                   nib_a, nib_b, nib_c;

	assign diff    = {1'b0, sample} - {1'b0, prev_q};
	assign step_ok = ($signed(diff) >= -13'sd7) && ($signed(diff) <= 13'sd7);
	assign nib_a   = sample[11:8];
	assign nib_b   = sample[7:4];
	assign nib_c   = sample[3:0];

	always_comb begin
		job       = '0;
		any       = 1'b0;
		prev_d    = prev_q;
		started_d = started_q;
		half_d    = half_q;
		held_d    = held_q;
		if (mode) begin
			if (half_q) begin
				job.b0 = {held_q, 4'h0};
				any    = 1'b1;
				half_d = 1'b0;
			end
		end else begin
			prev_d = sample;
			if (started_q && step_ok) begin
				if (half_q) begin
					job.b0 = {held_q, diff[3:0]};
					any    = 1'b1;
					half_d = 1'b0;
				end else begin
					held_d = diff[3:0];
					half_d = 1'b1;
				end
			end else begin
				started_d = 1'b1;
				if (started_q) begin
					// escape plus three raw nibbles: parity of the held half is unchanged
					job.two = 1'b1;
					any     = 1'b1;
					if (half_q) begin
						job.b0 = {held_q, nds_pkg::ESC_NIBBLE};
						job.b1 = {nib_a, nib_b};
						held_d = nib_c;
					end else begin
						job.b0 = {nds_pkg::ESC_NIBBLE, nib_a};
						job.b1 = {nib_b, nib_c};
					end
				end else begin
					any = 1'b1;
					if (half_q) begin
						job.two = 1'b1;
						job.b0  = {held_q, nib_a};
						job.b1  = {nib_b, nib_c};
						half_d  = 1'b0;
					end else begin
						job.b0 = {nib_a, nib_b};
						held_d = nib_c;
						half_d = 1'b1;
					end
				end
			end
		end
	end

	assign job_push = take & any;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q    <= '0;
			started_q <= 1'b0;
			half_q    <= 1'b0;
			held_q    <= '0;
		end else if (take) begin
			prev_q    <= prev_d;
			started_q <= started_d;
			half_q    <= half_d;
			held_q    <= held_d;
		end
	end

endmodule

// ===== rtl/nds_queue.sv =====
`timescale 1ns / 1ps

module nds_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  nds_pkg::job_t wr_data,
	input  logic          rd_en,
	output nds_pkg::job_t rd_data,
	output logic          full,
	output logic          empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULLC = CW'(DEPTH);

	nds_pkg::job_t  mem_q [DEPTH];
	logic [PW-1:0]  wptr_q, rptr_q;
	logic [CW-1:0]  count_q;
	logic           do_wr, do_rd;

	assign full    = (count_q == FULLC);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == LAST) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == LAST) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/nds_back.sv =====
`timescale 1ns / 1ps

module nds_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  nds_pkg::job_t q_data,
	output logic          q_pop,
	output logic          empty,
	output logic [7:0]    out_byte,
	output logic          last_of_run,
	input  logic          pop
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       second_q;
	logic [7:0] second_byte_q;
	logic       load;

	// output slot frees when empty or when its beat is taken
	assign load  = ~valid_q | pop;
	assign q_pop = load & ~second_q & ~q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (load) begin
			if (second_q) begin
				valid_q  <= 1'b1;
				second_q <= 1'b0;
			end else if (!q_empty) begin
				valid_q  <= 1'b1;
				second_q <= q_data.two;
			end else begin
				valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (second_q) begin
				byte_q <= second_byte_q;
				last_q <= 1'b1;
			end else if (!q_empty) begin
				byte_q        <= q_data.b0;
				last_q        <= ~q_data.two;
				second_byte_q <= q_data.b1;
			end
		end
	end

	assign empty       = ~valid_q;
	assign out_byte    = byte_q;
	assign last_of_run = last_q;

endmodule

// ===== rtl/nibble_delta_sample_encoder.sv =====
`timescale 1ns / 1ps

// channel  | handshake             | payload
// ---------+-----------------------+------------------------------
// input    | push / full           | mode[0:0], sample[11:0]
// result   | empty / pop           | out_byte[7:0], last_of_run
//
// an item is classified and packed in the cycle it is taken, so input is
// taken every cycle while the job queue has room; results leave one byte per
// cycle from the output register while pop is held; an escaped sample leaves
// as two bytes. bytes pass the job queue, then the output register. reset
// clears the coder state, the job queue and the output register; no clearing
// pass. either side may stall; the job queue absorbs the difference.

module nibble_delta_sample_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        mode,
	input  logic [11:0] sample,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        last_of_run
);

	logic          take;
	logic          job_push;
	nds_pkg::job_t job;
	nds_pkg::job_t q_data;
	logic          q_pop;
	logic          q_full;
	logic          q_empty;

	assign full = q_full;
	assign take = push & ~q_full;

	nds_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.mode     (mode),
		.sample   (sample),
		.job_push (job_push),
		.job      (job)
	);

	nds_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (job_push),
		.wr_data (job),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.full    (q_full),
		.empty   (q_empty)
	);

	nds_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.empty       (empty),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.pop         (pop)
	);

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;

	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_FLUSH  = 1'b1;
	localparam int   RAND_ITEMS  = 650;
	localparam int   MAX_GAP     = 13;
	localparam int   TAIL_CYCLES = 16;

	typedef struct packed {
		logic        m;
		logic [11:0] s;
		logic        typed;
		logic [1:0]  cnt;
		logic [7:0]  b0;
		logic [7:0]  b1;
	} dir_row_t;

	typedef struct {
		logic [7:0] val;
		logic       last;
	} coded_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        mode = MODE_SAMPLE;
	logic [11:0] sample = '0;
	logic        pop = 1'b0;
	logic        full;
	logic        empty;
	logic [7:0]  out_byte;
	logic        last_of_run;

	// coder state as seen from outside
	logic [11:0] last_sample;
	logic        have_sample;
	logic        nib_waiting;
	logic [3:0]  nib_held;

	coded_beat_t coded_q[$];
	logic [7:0]  item_bytes[$];

	int errors = 0;
	int items_sent = 0;
	int flushes_sent = 0;
	int bytes_checked = 0;
	int two_byte_items = 0;
	logic send_burst = 1'b0;
	logic recv_burst = 1'b0;

	dir_row_t dir_rows[21];

	nibble_delta_sample_encoder i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.mode        (mode),
		.sample      (sample),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic dir_row_t row(input logic m, input logic [11:0] s, input logic typed,
			input logic [1:0] cnt, input logic [7:0] b0, input logic [7:0] b1);
		dir_row_t r;
		r.m = m;
		r.s = s;
		r.typed = typed;
		r.cnt = cnt;
		r.b0 = b0;
		r.b1 = b1;
		return r;
	endfunction

	task automatic put_nibble(input logic [3:0] nib);
		if (nib_waiting) begin
			item_bytes.push_back({nib_held, nib});
			nib_waiting = 1'b0;
		end else begin
			nib_held = nib;
			nib_waiting = 1'b1;
		end
	endtask

	// advance the coder state by one item, leaving its bytes in item_bytes
	task automatic code_item(input logic m, input logic [11:0] s);
		int d;
		item_bytes.delete();
		if (m == MODE_FLUSH) begin
			if (nib_waiting) begin
				item_bytes.push_back({nib_held, 4'h0});
				nib_waiting = 1'b0;
			end
		end else begin
			d = int'(s) - int'(last_sample);
			if (have_sample && d >= -7 && d <= 7) begin
				put_nibble(d[3:0]);
			end else begin
				if (have_sample)
					put_nibble(nds_pkg::ESC_NIBBLE);
				put_nibble(s[11:8]);
				put_nibble(s[7:4]);
				put_nibble(s[3:0]);
				have_sample = 1'b1;
			end
			last_sample = s;
		end
	endtask

	task automatic queue_bytes();
		coded_beat_t cb;
		for (int i = 0; i < item_bytes.size(); i++) begin
			cb.val = item_bytes[i];
			cb.last = (i == item_bytes.size() - 1);
			coded_q.push_back(cb);
		end
		if (item_bytes.size() == 2)
			two_byte_items++;
	endtask

	// one input beat; typed rows take their bytes from the table, not the coder
	task automatic send_beat(input logic m, input logic [11:0] s, input logic typed,
			input logic [1:0] cnt, input logic [7:0] b0, input logic [7:0] b1);
		int gap;
		gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		mode <= m;
		sample <= s;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
		if (m == MODE_FLUSH)
			flushes_sent++;
		code_item(m, s);
		if (typed) begin
			item_bytes.delete();
			if (cnt > 0)
				item_bytes.push_back(b0);
			if (cnt > 1)
				item_bytes.push_back(b1);
		end
		queue_bytes();
	endtask

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (coded_q.size() != 0) @(posedge clk);
	endtask

	// result side
	initial begin
		int gap;
		coded_beat_t cb;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				recv_burst = ~recv_burst;
			gap = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			bytes_checked++;
			if (coded_q.size() == 0) begin
				$display("%0t: unexpected beat, got byte %h last %b",
					$time, out_byte, last_of_run);
				errors++;
			end else begin
				cb = coded_q.pop_front();
				if (out_byte !== cb.val) begin
					$display("%0t: out_byte mismatch, expected %h actual %h",
						$time, cb.val, out_byte);
					errors++;
				end
				if (last_of_run !== cb.last) begin
					$display("%0t: last_of_run mismatch, expected %b actual %b",
						$time, cb.last, last_of_run);
					errors++;
				end
			end
		end
	end

	initial begin
		int k;
		int d;
		int v;
		logic m;
		logic [11:0] s;

		last_sample = '0;
		have_sample = 1'b0;
		nib_waiting = 1'b0;
		nib_held = '0;

		dir_rows[0]  = row(MODE_FLUSH,  12'h000, 1'b1, 2'd0, 8'h00, 8'h00);
		dir_rows[1]  = row(MODE_SAMPLE, 12'hABC, 1'b1, 2'd1, 8'hAB, 8'h00);
		dir_rows[2]  = row(MODE_SAMPLE, 12'hAC3, 1'b0, 2'd0, 8'h00, 8'h00);
		dir_rows[3]  = row(MODE_SAMPLE, 12'hABC, 1'b0, 2'd0, 8'h00, 8'h00);
		dir_rows[4]  = row(MODE_FLUSH,  12'h000, 1'b0, 2'd0, 8'h00, 8'h00);
		dir_rows[5]  = row(MODE_FLUSH,  12'h000, 1'b0, 2'd0, 8'h00, 8'h00);
		dir_rows[6]  = row(MODE_SAMPLE, 12'hAC4, 1'b1, 2'd2, 8'h8A, 8'hC4);
		dir_rows[7]  = row(MODE_SAMPLE, 12'hABC, 1'b0, 2'd0, 8'h00, 8'h00);
		dir_rows[8]  = row(MODE_SAMPLE, 12'hFFF, 1'b1, 2'd2, 8'h8F, 8'hFF);
		dir_rows[9]  = row(MODE_SAMPLE, 12'h000, 1'b1, 2'd2, 8'h80, 8'h00);
		dir_rows[10] = row(MODE_SAMPLE, 12'h000, 1'b0, 2'd0, 8'h00, 8'h00);
		dir_rows[11] = row(MODE_SAMPLE, 12'hFFF, 1'b0, 2'd0, 8'h00, 8'h00);
		dir_rows[12] = row(MODE_SAMPLE, 12'hFF8, 1'b0, 2'd0, 8'h00, 8'h00);
		dir_rows[13] = row(MODE_SAMPLE, 12'hFFF, 1'b0, 2'd0, 8'h00, 8'h00);
		dir_rows[14] = row(MODE_FLUSH,  12'hFFF, 1'b0, 2'd0, 8'h00, 8'h00);
		dir_rows[15] = row(MODE_SAMPLE, 12'h555, 1'b0, 2'd0, 8'h00, 8'h00);
		dir_rows[16] = row(MODE_SAMPLE, 12'h556, 1'b0, 2'd0, 8'h00, 8'h00);
		dir_rows[17] = row(MODE_SAMPLE, 12'h556, 1'b0, 2'd0, 8'h00, 8'h00);
		dir_rows[18] = row(MODE_SAMPLE, 12'hAAA, 1'b0, 2'd0, 8'h00, 8'h00);
		dir_rows[19] = row(MODE_FLUSH,  12'hFFF, 1'b1, 2'd0, 8'h00, 8'h00);
		dir_rows[20] = row(MODE_SAMPLE, 12'h001, 1'b0, 2'd0, 8'h00, 8'h00);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_beat(dir_rows[i].m, dir_rows[i].s, dir_rows[i].typed,
				dir_rows[i].cnt, dir_rows[i].b0, dir_rows[i].b1);
		drain();

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 64 == 0)
				send_burst = ($urandom_range(0, 2) == 0);
			if (n == RAND_ITEMS / 2)
				drain();
			m = MODE_SAMPLE;
			k = $urandom_range(0, 99);
			if (k < 15) begin
				m = MODE_FLUSH;
				s = 12'($urandom);
			end else if (k < 75) begin
				// small steps dominate; exactly eight away must take the escape path
				d = (k < 65) ? $urandom_range(0, 14) - 7 : ($urandom_range(0, 1) ? 8 : -8);
				v = int'(last_sample) + d;
				if (v < 0 || v > 4095)
					v = int'(last_sample) - d;
				s = v[11:0];
			end else if (k < 80) begin
				s = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
			end else begin
				s = 12'($urandom_range(0, 4095));
			end
			send_beat(m, s, 1'b0, 2'd0, 8'h00, 8'h00);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (coded_q.size() != 0) begin
			$display("%0t: %0d expected beats never arrived", $time, coded_q.size());
			errors++;
		end

		$display("run covered %0d items (%0d flushes, %0d giving two bytes)",
			items_sent, flushes_sent, two_byte_items);
		$display("%0d result beats checked, %0d failures", bytes_checked, errors);
		if (errors == 0) begin
			$display("[nibble_delta_sample_encoder] OK");
		end else begin
			$display("[nibble_delta_sample_encoder] ERROR");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t: timeout", $time);
		$display("[nibble_delta_sample_encoder] ERROR");
		$finish;
	end

endmodule
